>>> sv/lbm_pkg.sv
// Shared types, constants and arithmetic helpers of the D2Q9 cell update.
package lbm_pkg;

  localparam int unsigned NDIR = 9;

  // Direction slots, in the order of the distributions on the ports.
  localparam int unsigned D_REST = 0;
  localparam int unsigned D_E    = 1;
  localparam int unsigned D_N    = 2;
  localparam int unsigned D_W    = 3;
  localparam int unsigned D_S    = 4;
  localparam int unsigned D_NE   = 5;
  localparam int unsigned D_NW   = 6;
  localparam int unsigned D_SW   = 7;
  localparam int unsigned D_SE   = 8;

  // Configuration register indexes.
  localparam logic [1:0] REG_DENSITY = 2'd0;
  localparam logic [1:0] REG_ACCEL   = 2'd1;
  localparam logic [1:0] REG_OMEGA   = 2'd2;

  localparam logic [30:0] DENSITY_RST = 31'd26843546;
  localparam logic [28:0] ACCEL_RST   = 29'd1342177;
  localparam logic [29:0] OMEGA_RST   = 30'd496599859;

  localparam logic signed [47:0] Q_ONE  = 48'sd268435456;
  localparam logic signed [63:0] W_REST = 64'sd119304647;
  localparam logic signed [63:0] W_AXIS = 64'sd29826162;
  localparam logic signed [63:0] W_DIAG = 64'sd7456540;

  // ceil(2^33 / 9): floor(p * RECIP9 / 2^33) equals floor(p / 9) for any 32-bit p.
  localparam logic [63:0] RECIP9 = 64'd954437177;

  // Pipeline depth figures.
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  localparam int unsigned NSTAGE    = 25;
  localparam int unsigned NITEM     = NSTAGE - 1;

  typedef logic [8:0][31:0] dist_t;

  typedef struct packed {
    logic               op;
    logic               obst;
    dist_t              f;
    logic signed [35:0] rho;
    logic [31:0]        p;
    logic [31:0]        a1;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x > 48'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Equilibrium bracket for one moving direction: 1 + 4.5 u^2 - 1.5 |u|^2 + 3 u.
  function automatic logic signed [31:0] term_of(input logic signed [32:0] u,
                                                 input logic [34:0] squ,
                                                 input logic [36:0] usq);
    logic signed [47:0] nine_half;
    logic signed [47:0] acc;
    nine_half = $signed({13'b0, squ}) * 48'sd9;
    nine_half = nine_half >>> 1;
    acc = Q_ONE + nine_half - $signed({11'b0, usq}) + 48'sd3 * 48'(u);
    return sat32(acc);
  endfunction

endpackage

>>> sv/lbm_in_if.sv
// Input channel of the cell update: one lattice cell per transaction.
interface lbm_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic               is_obstacle;
  logic signed [31:0] f_rest;
  logic signed [31:0] f_east;
  logic signed [31:0] f_north;
  logic signed [31:0] f_west;
  logic signed [31:0] f_south;
  logic signed [31:0] f_northeast;
  logic signed [31:0] f_northwest;
  logic signed [31:0] f_southwest;
  logic signed [31:0] f_southeast;

  modport source (output valid, opcode, is_obstacle, f_rest, f_east, f_north, f_west,
                  f_south, f_northeast, f_northwest, f_southwest, f_southeast,
                  input ready);
  modport sink (input valid, opcode, is_obstacle, f_rest, f_east, f_north, f_west,
                f_south, f_northeast, f_northwest, f_southwest, f_southeast,
                output ready);
endinterface

>>> sv/lbm_out_if.sv
// Output channel of the cell update: one updated cell per transaction.
interface lbm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_rest;
  logic signed [31:0] out_east;
  logic signed [31:0] out_north;
  logic signed [31:0] out_west;
  logic signed [31:0] out_south;
  logic signed [31:0] out_northeast;
  logic signed [31:0] out_northwest;
  logic signed [31:0] out_southwest;
  logic signed [31:0] out_southeast;
  logic               bad_density;

  modport source (output valid, out_rest, out_east, out_north, out_west, out_south,
                  out_northeast, out_northwest, out_southwest, out_southeast,
                  bad_density, input ready);
  modport sink (input valid, out_rest, out_east, out_north, out_west, out_south,
                out_northeast, out_northwest, out_southwest, out_southeast,
                bad_density, output ready);
endinterface

>>> sv/lbm_div.sv
// Pipelined signed fractional divider: sat32(num * 2^28 / den), zero for den <= 0.
module lbm_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [35:0] num,
  input  logic signed [35:0] den,
  output logic signed [31:0] quo
);
  import lbm_pkg::*;

  logic [34:0] rem  [DIV_STEPS+1];
  logic [30:0] qbit [DIV_STEPS+1];
  logic [34:0] dv   [DIV_STEPS+1];
  logic [2:0]  mlo  [DIV_STEPS+1];
  logic        neg  [DIV_STEPS+1];
  logic        ovf  [DIV_STEPS+1];
  logic        zero [DIV_STEPS+1];

  logic [35:0] mag;
  logic        den_bad;

  // One restoring step: shift in a numerator bit, subtract when it fits.
  function automatic logic [35:0] dstep(input logic [34:0] r, input logic [34:0] d,
                                        input logic b);
    logic [35:0] t;
    logic [35:0] res;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      res = {1'b1, t[34:0]};
    end else begin
      res = {1'b0, t[34:0]};
    end
    return res;
  endfunction

  // Numerator is |num| shifted up by 28, so only bits 30..28 below the
  // initial remainder are non-zero.
  function automatic logic nbit(input logic [2:0] lo, input int i);
    logic b;
    if (i >= 28) begin
      b = lo[i-28];
    end else begin
      b = 1'b0;
    end
    return b;
  endfunction

  assign mag     = num[35] ? 36'(-num) : 36'(num);
  assign den_bad = (den <= 36'sd0);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= 35'(mag >> 3);
      qbit[0] <= '0;
      dv[0]   <= den[34:0];
      mlo[0]  <= mag[2:0];
      neg[0]  <= num[35];
      zero[0] <= den_bad;
      ovf[0]  <= ({2'b0, mag} >= {den[34:0], 3'b0});
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int BA = 30 - 2 * j;
    localparam int BB = 29 - 2 * j;
    logic [35:0] s1;
    logic [35:0] s2;
    logic [30:0] qn;

    always_comb begin
      s1 = dstep(rem[j], dv[j], nbit(mlo[j], BA));
      qn = qbit[j];
      qn[BA] = s1[35];
      s2 = s1;
      if (BB >= 0) begin
        s2 = dstep(s1[34:0], dv[j], nbit(mlo[j], BB));
        qn[(BB >= 0) ? BB : 0] = s2[35];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= s2[34:0];
        qbit[j+1] <= qn;
        dv[j+1]   <= dv[j];
        mlo[j+1]  <= mlo[j];
        neg[j+1]  <= neg[j];
        ovf[j+1]  <= ovf[j];
        zero[j+1] <= zero[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero[DIV_STEPS]) begin
        quo <= '0;
      end else if (ovf[DIV_STEPS]) begin
        quo <= neg[DIV_STEPS] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else if (neg[DIV_STEPS]) begin
        quo <= -$signed({1'b0, qbit[DIV_STEPS]});
      end else begin
        quo <= $signed({1'b0, qbit[DIV_STEPS]});
      end
    end
  end

endmodule

>>> sv/lbm_d2q9_cell_update.sv
// Top level of the D2Q9 lattice Boltzmann cell update pipeline.
//
// Each transaction on cell_in carries one lattice cell: nine signed Q4.28
// distributions, an obstacle flag and an opcode. Collide mode bounces obstacle
// cells back and relaxes fluid cells towards the second-order BGK equilibrium
// by omega; a cell whose density is not positive is relaxed with zero velocity
// and flagged on bad_density. Accelerate mode shifts density*accel/9 and /36
// from the west-going to the east-going directions of fluid cells when all
// three west-going values stay positive. The block is a 25-stage pipeline
// that takes one cell every clock cycle and returns each result in order; the
// depth is set mainly by the two velocity dividers, which retire two quotient
// bits per stage, one in the last. When cell_out is held off the whole pipeline
// holds, so cell_in.ready falls only while a finished result waits. The three
// registers are written through cfg_we, cfg_index and cfg_data and should only
// be changed while no cell is in flight; writes to an unused index are ignored.
module lbm_d2q9_cell_update (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  lbm_in_if.sink      cell_in,
  lbm_out_if.source   cell_out
);
  import lbm_pkg::*;

  logic [30:0] fluid_density;
  logic [28:0] accel_strength;
  logic [29:0] relax_rate;

  logic              adv;
  logic [NSTAGE-1:0] vld;
  item_t             item [NITEM];

  // Stage 1 inputs.
  logic signed [31:0] fin [NDIR];
  logic signed [35:0] rho_c;
  logic signed [35:0] mx_c;
  logic signed [35:0] my_c;
  logic [59:0]        pprod;
  logic signed [35:0] mx1;
  logic signed [35:0] my1;
  item_t              item1_c;

  // Divider outputs, aligned with stage 19.
  logic signed [31:0] ux_d;
  logic signed [31:0] uy_d;

  // Stage 20 and 21.
  logic signed [31:0] ux20, uy20, ud20, ua20;
  logic [34:0]        sqx20, sqy20;
  logic signed [31:0] rw20 [3];
  logic signed [31:0] ux21, uy21, ud21, ua21;
  logic [34:0]        sqx21, sqy21, sqd21, sqa21;
  logic [36:0]        usq21;
  logic signed [31:0] rw21 [3];
  logic signed [31:0] rs_c;
  logic signed [31:0] ud_c, ua_c;

  // Stage 22 to 24.
  logic signed [31:0] term22 [NDIR];
  logic signed [31:0] rw22 [3];
  logic signed [31:0] feq23 [NDIR];
  logic signed [63:0] prod24 [NDIR];
  logic signed [32:0] dlt_c [NDIR];

  // Final stage selection.
  logic signed [31:0] res_c [NDIR];
  logic signed [31:0] outr  [NDIR];
  logic               bad_c;
  logic               bad_r;
  logic [31:0]        a2_c;
  logic               acc_ok;

  // Equilibrium weight group of each direction: rest, axis or diagonal.
  function automatic int unsigned wgrp(input int unsigned k);
    int unsigned g;
    if (k == D_REST) begin
      g = 0;
    end else if (k <= D_S) begin
      g = 1;
    end else begin
      g = 2;
    end
    return g;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fluid_density  <= DENSITY_RST;
      accel_strength <= ACCEL_RST;
      relax_rate     <= OMEGA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DENSITY: fluid_density  <= cfg_data;
        REG_ACCEL:   accel_strength <= cfg_data[28:0];
        REG_OMEGA:   relax_rate     <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one; it holds only while the output register
  // holds a result that has not been taken.
  assign adv           = !vld[NSTAGE-1] || cell_out.ready;
  assign cell_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], cell_in.valid};
    end
  end

  // Stage 1: density, momenta and the accelerate product.
  assign fin[D_REST] = cell_in.f_rest;
  assign fin[D_E]    = cell_in.f_east;
  assign fin[D_N]    = cell_in.f_north;
  assign fin[D_W]    = cell_in.f_west;
  assign fin[D_S]    = cell_in.f_south;
  assign fin[D_NE]   = cell_in.f_northeast;
  assign fin[D_NW]   = cell_in.f_northwest;
  assign fin[D_SW]   = cell_in.f_southwest;
  assign fin[D_SE]   = cell_in.f_southeast;

  always_comb begin
    rho_c = '0;
    for (int k = 0; k < NDIR; k++) begin
      rho_c = rho_c + 36'(fin[k]);
    end
    mx_c = (36'(fin[D_E]) + 36'(fin[D_NE]) + 36'(fin[D_SE]))
         - (36'(fin[D_W]) + 36'(fin[D_NW]) + 36'(fin[D_SW]));
    my_c = (36'(fin[D_N]) + 36'(fin[D_NE]) + 36'(fin[D_NW]))
         - (36'(fin[D_S]) + 36'(fin[D_SW]) + 36'(fin[D_SE]));
    pprod = 60'(fluid_density) * 60'(accel_strength);
  end

  // Stage 2: the accelerate amount for the axis directions.
  always_comb begin
    item1_c    = item[0];
    item1_c.a1 = 32'((64'(item[0].p) * RECIP9) >> 33);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item[0].op   <= cell_in.opcode;
      item[0].obst <= cell_in.is_obstacle;
      for (int k = 0; k < NDIR; k++) begin
        item[0].f[k] <= fin[k];
      end
      item[0].rho <= rho_c;
      item[0].p   <= pprod[59:28];
      item[0].a1  <= '0;
      mx1         <= mx_c;
      my1         <= my_c;
      item[1]     <= item1_c;
      for (int s = 2; s < NITEM; s++) begin
        item[s] <= item[s-1];
      end
    end
  end

  // Stages 2 to 19: velocity components.
  lbm_div u_div_x (.clk(clk), .en(adv), .num(mx1), .den(item[0].rho), .quo(ux_d));
  lbm_div u_div_y (.clk(clk), .en(adv), .num(my1), .den(item[0].rho), .quo(uy_d));

  // Stage 20: diagonal velocities, squares of the axis velocities, weighted
  // densities.
  always_comb begin
    rs_c = sat32(48'(item[DIV_LAT].rho));
    ud_c = sat32(48'(ux_d) + 48'(uy_d));
    ua_c = sat32(48'(uy_d) - 48'(ux_d));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux20    <= ux_d;
      uy20    <= uy_d;
      ud20    <= ud_c;
      ua20    <= ua_c;
      sqx20   <= 35'((64'(ux_d) * 64'(ux_d)) >>> 28);
      sqy20   <= 35'((64'(uy_d) * 64'(uy_d)) >>> 28);
      rw20[0] <= 32'((64'(rs_c) * W_REST) >>> 28);
      rw20[1] <= 32'((64'(rs_c) * W_AXIS) >>> 28);
      rw20[2] <= 32'((64'(rs_c) * W_DIAG) >>> 28);
    end
  end

  // Stage 21: squares of the diagonal velocities and 1.5 |u|^2.
  always_ff @(posedge clk) begin
    if (adv) begin
      ux21  <= ux20;
      uy21  <= uy20;
      ud21  <= ud20;
      ua21  <= ua20;
      sqx21 <= sqx20;
      sqy21 <= sqy20;
      sqd21 <= 35'((64'(ud20) * 64'(ud20)) >>> 28);
      sqa21 <= 35'((64'(ua20) * 64'(ua20)) >>> 28);
      usq21 <= 37'((39'(3) * (39'(sqx20) + 39'(sqy20))) >> 1);
      rw21  <= rw20;
    end
  end

  // Stage 22: equilibrium brackets of all nine directions.
  always_ff @(posedge clk) begin
    if (adv) begin
      term22[D_REST] <= sat32(Q_ONE - $signed({11'b0, usq21}));
      term22[D_E]    <= term_of(33'(ux21), sqx21, usq21);
      term22[D_W]    <= term_of(-33'(ux21), sqx21, usq21);
      term22[D_N]    <= term_of(33'(uy21), sqy21, usq21);
      term22[D_S]    <= term_of(-33'(uy21), sqy21, usq21);
      term22[D_NE]   <= term_of(33'(ud21), sqd21, usq21);
      term22[D_SW]   <= term_of(-33'(ud21), sqd21, usq21);
      term22[D_NW]   <= term_of(33'(ua21), sqa21, usq21);
      term22[D_SE]   <= term_of(-33'(ua21), sqa21, usq21);
      rw22           <= rw21;
    end
  end

  // Stage 23: equilibrium distributions.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NDIR; k++) begin
        feq23[k] <= sat32(48'((64'(rw22[wgrp(k)]) * 64'(term22[k])) >>> 28));
      end
    end
  end

  // Stage 24: omega times the distance to equilibrium.
  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      dlt_c[k] = 33'(feq23[k]) - 33'($signed(item[NITEM-2].f[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NDIR; k++) begin
        prod24[k] <= $signed({34'b0, relax_rate}) * 64'(dlt_c[k]);
      end
    end
  end

  // Stage 25: mode selection into the output register.
  always_comb begin
    a2_c   = item[NITEM-1].a1 >> 2;
    acc_ok = (34'($signed(item[NITEM-1].f[D_W])) - $signed({2'b0, item[NITEM-1].a1})
              > 34'sd0)
          && (34'($signed(item[NITEM-1].f[D_NW])) - $signed({2'b0, a2_c}) > 34'sd0)
          && (34'($signed(item[NITEM-1].f[D_SW])) - $signed({2'b0, a2_c}) > 34'sd0);
    bad_c = 1'b0;
    for (int k = 0; k < NDIR; k++) begin
      res_c[k] = $signed(item[NITEM-1].f[k]);
    end
    if (item[NITEM-1].op) begin
      if (!item[NITEM-1].obst && acc_ok) begin
        res_c[D_E]  = sat32(48'($signed(item[NITEM-1].f[D_E]))
                            + $signed({16'b0, item[NITEM-1].a1}));
        res_c[D_NE] = sat32(48'($signed(item[NITEM-1].f[D_NE])) + $signed({16'b0, a2_c}));
        res_c[D_SE] = sat32(48'($signed(item[NITEM-1].f[D_SE])) + $signed({16'b0, a2_c}));
        res_c[D_W]  = $signed(item[NITEM-1].f[D_W] - item[NITEM-1].a1);
        res_c[D_NW] = $signed(item[NITEM-1].f[D_NW] - a2_c);
        res_c[D_SW] = $signed(item[NITEM-1].f[D_SW] - a2_c);
      end
    end else if (item[NITEM-1].obst) begin
      // Bounce-back: each direction takes its opposite.
      res_c[D_E]  = $signed(item[NITEM-1].f[D_W]);
      res_c[D_W]  = $signed(item[NITEM-1].f[D_E]);
      res_c[D_N]  = $signed(item[NITEM-1].f[D_S]);
      res_c[D_S]  = $signed(item[NITEM-1].f[D_N]);
      res_c[D_NE] = $signed(item[NITEM-1].f[D_SW]);
      res_c[D_SW] = $signed(item[NITEM-1].f[D_NE]);
      res_c[D_NW] = $signed(item[NITEM-1].f[D_SE]);
      res_c[D_SE] = $signed(item[NITEM-1].f[D_NW]);
    end else begin
      bad_c = (item[NITEM-1].rho <= 36'sd0);
      for (int k = 0; k < NDIR; k++) begin
        res_c[k] = sat32(48'($signed(item[NITEM-1].f[k])) + 48'(prod24[k] >>> 28));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outr  <= res_c;
      bad_r <= bad_c;
    end
  end

  assign cell_out.valid         = vld[NSTAGE-1];
  assign cell_out.out_rest      = outr[D_REST];
  assign cell_out.out_east      = outr[D_E];
  assign cell_out.out_north     = outr[D_N];
  assign cell_out.out_west      = outr[D_W];
  assign cell_out.out_south     = outr[D_S];
  assign cell_out.out_northeast = outr[D_NE];
  assign cell_out.out_northwest = outr[D_NW];
  assign cell_out.out_southwest = outr[D_SW];
  assign cell_out.out_southeast = outr[D_SE];
  assign cell_out.bad_density   = bad_r;

  // A stalled pipeline keeps every transaction where it is.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  // The input side is held off only by an untaken result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    cell_in.ready == (!cell_out.valid || cell_out.ready))
    else $error("input ready does not follow the output register");

  // An accepted cell always enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    cell_in.valid && cell_in.ready |=> vld[0])
    else $error("accepted cell lost at pipeline entry");

endmodule
